>>> sv/bucketed_hash_table_engine_core_assert.svh
// Assertion macros for the checker file of the hash table engine.
// Each macro expects clk_i and rst_ni in scope.
`ifndef BUCKETED_HASH_TABLE_ENGINE_CORE_ASSERT_SVH
`define BUCKETED_HASH_TABLE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication.
`define BHTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BHTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bhte_pkg.sv
// Shared types and constants for the bucketed hash table engine.
// No dependencies.
package bhte_pkg;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 31;
  localparam int VAL_W    = 16;
  localparam int BUCKET_W = 4;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_LOOKUP = 2'd1,
    FN_REMOVE = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

endpackage

>>> sv/bhte_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bhte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/bucketed_hash_table_engine_core.sv
// Bucketed key-value table: top level with the row FSM around one bucket RAM.
// Depends on bhte_pkg and bhte_ram.
//
// Each accepted word (start high while busy is low) performs insert, lookup or
// remove on the bucket the caller names; the bucket index is reduced modulo
// NUM_BUCKETS. One RAM row holds all WAYS slots of a bucket (valid, key, value),
// so the row is read at the accept edge, then compared across all ways and
// written back in the following cycle. The result word appears on status_o,
// found_value_o and entry_total_o for one cycle with done_o high, in the cycle
// after that, and the next word may be accepted in that same cycle. There is no
// result backpressure. After reset the block clears the RAM one row per cycle,
// all NUM_BUCKETS rows in turn, with busy held high.
module bucketed_hash_table_engine_core #(
  parameter int NUM_BUCKETS = 16,
  parameter int WAYS        = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [bhte_pkg::FUNC_W-1:0]   func_i,
  input  logic [bhte_pkg::KEY_W-1:0]    key_i,
  input  logic [bhte_pkg::VAL_W-1:0]    value_i,
  input  logic [bhte_pkg::BUCKET_W-1:0] bucket_i,
  output logic                       done_o,
  output logic [bhte_pkg::STATUS_W-1:0] status_o,
  output logic [bhte_pkg::VAL_W-1:0]    found_value_o,
  output logic [bhte_pkg::TOTAL_W-1:0]  entry_total_o
);
  import bhte_pkg::*;

  localparam int SLOTS    = NUM_BUCKETS * WAYS;
  localparam int BIDX_W   = $clog2(NUM_BUCKETS);
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int ROW_W    = WAYS * $bits(slot_t);
  localparam int BIN_SPAN = 2 ** BUCKET_W;

  state_e                state_q, state_d;
  logic [BIDX_W-1:0]     clr_q, clr_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [FUNC_W-1:0]     func_q;
  logic [KEY_W-1:0]      key_q;
  logic [VAL_W-1:0]      value_q;
  logic [BIDX_W-1:0]     bucket_q;
  logic                  done_q, done_d;
  status_e               status_q, status_d;
  logic [VAL_W-1:0]      found_q, found_d;
  logic                  accept;

  logic [BIDX_W-1:0]     bucket_map [BIN_SPAN];
  logic                  ram_we;
  logic [BIDX_W-1:0]     ram_waddr;
  logic [ROW_W-1:0]      ram_rdata;
  slot_t [WAYS-1:0]      row_rd, row_wr;

  logic                  hit_any, free_any;
  logic [WAY_W-1:0]      hit_way, free_way;

  // Modulo reduction of the bucket index, resolved at elaboration.
  for (genvar i = 0; i < BIN_SPAN; i++) begin : g_bmap
    assign bucket_map[i] = BIDX_W'(i % NUM_BUCKETS);
  end

  bhte_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (row_wr),
    .re_i    (accept),
    .raddr_i (bucket_map[bucket_i]),
    .rdata_o (ram_rdata)
  );

  assign row_rd = ram_rdata;

  // Lowest matching way and lowest free way; scan from the top so way 0 wins.
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_rd[w].valid && (row_rd[w].key == key_q)) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!row_rd[w].valid) begin
        free_any = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    ram_we    = 1'b0;
    ram_waddr = bucket_q;
    row_wr    = row_rd;
    done_d    = 1'b0;
    status_d  = ST_OK;
    found_d   = '0;
    accept    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        row_wr    = '0;
        clr_d     = clr_q + BIDX_W'(1);
        if (clr_q == BIDX_W'(NUM_BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          accept  = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        case (func_q)
          FN_INSERT: begin
            if (hit_any) begin
              status_d = ST_PRESENT;
            end else if (free_any) begin
              ram_we                 = 1'b1;
              row_wr[free_way].valid = 1'b1;
              row_wr[free_way].key   = key_q;
              row_wr[free_way].value = value_q;
              cnt_d                  = cnt_q + CNT_W'(1);
            end else begin
              status_d = ST_FULL;
            end
          end
          FN_LOOKUP: begin
            if (hit_any) begin
              found_d = row_rd[hit_way].value;
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          FN_REMOVE: begin
            if (hit_any) begin
              ram_we                = 1'b1;
              row_wr[hit_way].valid = 1'b0;
              if (cnt_q != '0) begin
                cnt_d = cnt_q - CNT_W'(1);
              end
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          default: ;  // unused code: no change, status ok
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= func_i;
      key_q    <= key_i;
      value_q  <= value_i;
      bucket_q <= bucket_map[bucket_i];
    end
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_value_o = found_q;
  // Count settles at the same edge that raises done_o.
  assign entry_total_o = TOTAL_W'(cnt_q);

endmodule

>>> sv/bhte_checker.sv
// Port-level checker for the hash table engine, bound to the top level.
// Depends on bhte_pkg and the assertion macro header.
`include "bucketed_hash_table_engine_core_assert.svh"

module bhte_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [bhte_pkg::STATUS_W-1:0] status_o,
  input logic [bhte_pkg::VAL_W-1:0]    found_value_o
);
  import bhte_pkg::*;

  `BHTE_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy,
    "busy not raised after an accepted word")

  `BHTE_ASSERT_NOW(a_done_latency, done_o, $past(start && !busy, 2),
    "result word without an accept two cycles earlier")

  `BHTE_ASSERT_NOW(a_done_idle, done_o, !busy,
    "result word shown while busy")

  `BHTE_ASSERT_NOW(a_found_zero, done_o && (status_o != ST_OK), found_value_o == '0,
    "nonzero found value on a failed operation")

endmodule

bind bucketed_hash_table_engine_core bhte_checker u_bhte_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .found_value_o (found_value_o)
);

>>> test/bhte_result_checker.sv
// Result checker for the bucketed hash table engine testbench.
// Watches the command and result words, predicts each result and counts failures.
// Depends on bhte_pkg.
`timescale 1ns / 100ps

module bhte_result_checker #(
  parameter int NUM_BUCKETS = 16,
  parameter int WAYS        = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [bhte_pkg::FUNC_W-1:0]   func_i,
  input  logic [bhte_pkg::KEY_W-1:0]    key_i,
  input  logic [bhte_pkg::VAL_W-1:0]    value_i,
  input  logic [bhte_pkg::BUCKET_W-1:0] bucket_i,
  input  logic                          done_i,
  input  logic [bhte_pkg::STATUS_W-1:0] status_i,
  input  logic [bhte_pkg::VAL_W-1:0]    found_value_i,
  input  logic [bhte_pkg::TOTAL_W-1:0]  entry_total_i,
  output int                            error_count_o,
  output int                            pending_o,
  output int                            checked_o,
  output int                            full_seen_o,
  output int                            peak_total_o
);
  import bhte_pkg::*;

  typedef struct {
    logic [FUNC_W-1:0]   func;
    logic [KEY_W-1:0]    key;
    logic [BUCKET_W-1:0] bucket;
    status_e             status;
    logic [VAL_W-1:0]    found;
    logic [TOTAL_W-1:0]  total;
  } table_result_t;

  // shadow copy of the table
  logic             row_used  [NUM_BUCKETS][WAYS];
  logic [KEY_W-1:0] row_key   [NUM_BUCKETS][WAYS];
  logic [VAL_W-1:0] row_value [NUM_BUCKETS][WAYS];
  int unsigned      held_entries;

  table_result_t expected_results[$];

  task automatic flag_error(input string what);
    error_count_o++;
    if (error_count_o <= 10) $display("[%0t] ERROR: %s", $time, what);
  endtask

  function automatic table_result_t apply_table_op(input logic [FUNC_W-1:0]   fn,
                                                   input logic [KEY_W-1:0]    key,
                                                   input logic [VAL_W-1:0]    val,
                                                   input logic [BUCKET_W-1:0] bkt);
    table_result_t r;
    int            b;
    int            hit;
    int            free_way;
    b        = int'(bkt) % NUM_BUCKETS;
    hit      = -1;
    free_way = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (row_used[b][w] && row_key[b][w] == key && hit < 0) hit = w;
      if (!row_used[b][w] && free_way < 0) free_way = w;
    end
    r.func   = fn;
    r.key    = key;
    r.bucket = bkt;
    r.status = ST_OK;
    r.found  = '0;
    case (fn)
      FN_INSERT: begin
        if (hit >= 0) begin
          r.status = ST_PRESENT;
        end else if (free_way >= 0) begin
          // lowest free way takes the new entry
          row_used[b][free_way]  = 1'b1;
          row_key[b][free_way]   = key;
          row_value[b][free_way] = val;
          held_entries++;
        end else begin
          r.status = ST_FULL;
        end
      end
      FN_LOOKUP: begin
        if (hit >= 0) r.found = row_value[b][hit];
        else r.status = ST_NOT_FOUND;
      end
      FN_REMOVE: begin
        if (hit >= 0) begin
          row_used[b][hit] = 1'b0;
          if (held_entries > 0) held_entries--;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: ;  // unused code: no change, plain ok
    endcase
    r.total = held_entries[TOTAL_W-1:0];
    return r;
  endfunction

  initial begin
    error_count_o = 0;
    pending_o     = 0;
    checked_o     = 0;
    full_seen_o   = 0;
    peak_total_o  = 0;
    held_entries  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t want;
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BUCKETS; b++)
        for (int w = 0; w < WAYS; w++) row_used[b][w] = 1'b0;
      held_entries = 0;
      expected_results.delete();
    end else begin
      // compare first: a result never belongs to the word accepted at this edge
      if (done_i === 1'b1) begin
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result word with nothing pending: status %0d value %h total %0d",
                               status_i, found_value_i, entry_total_i));
        end else begin
          want = expected_results.pop_front();
          checked_o++;
          if (status_i !== want.status)
            flag_error($sformatf("status: expected %0d, got %0d (op %0d key %h bucket %0d)",
                                 want.status, status_i, want.func, want.key, want.bucket));
          if (found_value_i !== want.found)
            flag_error($sformatf("found_value: expected %h, got %h (op %0d key %h bucket %0d)",
                                 want.found, found_value_i, want.func, want.key, want.bucket));
          if (entry_total_i !== want.total)
            flag_error($sformatf("entry_total: expected %0d, got %0d (op %0d key %h bucket %0d)",
                                 want.total, entry_total_i, want.func, want.key, want.bucket));
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        want = apply_table_op(func_i, key_i, value_i, bucket_i);
        if (want.status == ST_FULL) full_seen_o++;
        if (int'(held_entries) > peak_total_o) peak_total_o = int'(held_entries);
        expected_results.push_back(want);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

>>> test/tb_bucketed_hash_table_engine_core.sv
// Testbench top for the bucketed hash table engine: clock, reset, command stimulus, verdict.
// Depends on bhte_pkg, bucketed_hash_table_engine_core and bhte_result_checker.
`timescale 1ns / 100ps

module tb_bucketed_hash_table_engine_core;
  import bhte_pkg::*;

  localparam int                NUM_BUCKETS  = 16;
  localparam int                WAYS         = 4;
  localparam int                POOL_KEYS    = 6;
  localparam int                PHASE_WORDS  = 667;
  localparam int                TAIL_CYCLES  = 8;
  localparam int                CYCLE_LIMIT  = 400000;
  localparam logic [FUNC_W-1:0] FN_UNUSED    = 2'd3;
  localparam logic [KEY_W-1:0]  KEY_MAX      = {KEY_W{1'b1}};
  localparam logic [VAL_W-1:0]  VAL_MAX      = {VAL_W{1'b1}};
  localparam logic [BUCKET_W-1:0] BKT_LAST   = BUCKET_W'(NUM_BUCKETS - 1);

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [FUNC_W-1:0]   func_i;
  logic [KEY_W-1:0]    key_i;
  logic [VAL_W-1:0]    value_i;
  logic [BUCKET_W-1:0] bucket_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [VAL_W-1:0]    found_value_o;
  logic [TOTAL_W-1:0]  entry_total_o;

  int error_count;
  int pending;
  int checked;
  int full_seen;
  int peak_total;
  int cycle_count;
  int idle_pct;
  int op_count [4];

  logic [KEY_W-1:0] key_pool [NUM_BUCKETS][POOL_KEYS];

  bucketed_hash_table_engine_core #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .bucket_i      (bucket_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_value_o (found_value_o),
    .entry_total_o (entry_total_o)
  );

  bhte_result_checker #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .func_i        (func_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .bucket_i      (bucket_i),
    .done_i        (done_o),
    .status_i      (status_o),
    .found_value_i (found_value_o),
    .entry_total_i (entry_total_o),
    .error_count_o (error_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .full_seen_o   (full_seen),
    .peak_total_o  (peak_total)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d words still pending", cycle_count, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Drive one command word at the falling edge and hold it until accepted.
  // Idle cycles carry junk on the fields with start low.
  task automatic send_word(input logic [FUNC_W-1:0]   fn,
                           input logic [KEY_W-1:0]    key,
                           input logic [VAL_W-1:0]    val,
                           input logic [BUCKET_W-1:0] bkt);
    while ($urandom_range(99) < idle_pct) begin
      start    <= 1'b0;
      func_i   <= FUNC_W'($urandom);
      key_i    <= KEY_W'($urandom);
      value_i  <= VAL_W'($urandom);
      bucket_i <= BUCKET_W'($urandom);
      @(negedge clk_i);
    end
    start    <= 1'b1;
    func_i   <= fn;
    key_i    <= key;
    value_i  <= val;
    bucket_i <= bkt;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    op_count[fn]++;
    @(negedge clk_i);
  endtask

  task automatic send_random_word();
    logic [FUNC_W-1:0]   fn;
    logic [KEY_W-1:0]    key;
    logic [BUCKET_W-1:0] bkt;
    int                  sel;
    sel = $urandom_range(99);
    if (sel < 45)      fn = FN_INSERT;
    else if (sel < 70) fn = FN_LOOKUP;
    else if (sel < 95) fn = FN_REMOVE;
    else               fn = FN_UNUSED;
    bkt = BUCKET_W'($urandom_range(NUM_BUCKETS - 1));
    // mostly a small per-bucket key set so hits, duplicates and full buckets are common
    if ($urandom_range(99) < 85) key = key_pool[bkt][$urandom_range(POOL_KEYS - 1)];
    else key = KEY_W'($urandom);
    send_word(fn, key, VAL_W'($urandom), bkt);
  endtask

  initial begin
    for (int i = 0; i < 4; i++) op_count[i] = 0;
    for (int b = 0; b < NUM_BUCKETS; b++)
      for (int k = 0; k < POOL_KEYS; k++) key_pool[b][k] = KEY_W'($urandom);
    idle_pct = 29;
    rst_ni   = 1'b0;
    start    = 1'b0;
    func_i   = '0;
    key_i    = '0;
    value_i  = '0;
    bucket_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty table, extremes, duplicate, full bucket, way reuse, unused code
    send_word(FN_LOOKUP, '0, '0, '0);
    send_word(FN_REMOVE, '0, '0, '0);
    send_word(FN_INSERT, '0, '0, '0);
    send_word(FN_INSERT, KEY_MAX, VAL_MAX, '0);
    send_word(FN_INSERT, '0, 16'h5a5a, '0);
    send_word(FN_INSERT, 31'd1, 16'h0001, '0);
    send_word(FN_INSERT, 31'd2, 16'h8000, '0);
    send_word(FN_INSERT, 31'd3, 16'h00ff, '0);
    send_word(FN_LOOKUP, KEY_MAX, '0, '0);
    send_word(FN_LOOKUP, '0, VAL_MAX, '0);
    send_word(FN_LOOKUP, KEY_MAX, '0, BKT_LAST);
    send_word(FN_INSERT, KEY_MAX, 16'h1234, BKT_LAST);
    send_word(FN_LOOKUP, KEY_MAX, '0, BKT_LAST);
    send_word(FN_REMOVE, '0, '0, '0);
    send_word(FN_INSERT, 31'd5, 16'habcd, '0);
    send_word(FN_LOOKUP, 31'd5, '0, '0);
    send_word(FN_LOOKUP, '0, '0, '0);
    send_word(FN_UNUSED, 31'd5, VAL_MAX, '0);
    send_word(FN_UNUSED, KEY_MAX, VAL_MAX, BKT_LAST);
    send_word(FN_REMOVE, KEY_MAX, '0, BKT_LAST);
    send_word(FN_REMOVE, KEY_MAX, '0, BKT_LAST);
    send_word(FN_LOOKUP, KEY_MAX, '0, BKT_LAST);
    send_word(FN_REMOVE, 31'd2, '0, '0);
    send_word(FN_INSERT, 31'h2aaa_aaaa, 16'h5555, '0);

    repeat (PHASE_WORDS) send_random_word();
    idle_pct = 73;
    repeat (PHASE_WORDS) send_random_word();
    idle_pct = 0;
    repeat (PHASE_WORDS) send_random_word();
    start <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);

    $display("Sent %0d insert, %0d lookup, %0d remove, %0d unused-code words; %0d results checked",
             op_count[FN_INSERT], op_count[FN_LOOKUP], op_count[FN_REMOVE],
             op_count[FN_UNUSED], checked);
    $display("Bucket-full results: %0d, peak entry count: %0d, mismatches: %0d",
             full_seen, peak_total, error_count);
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
